>>> rtl/escaped_rle_byte_encoder_unit_macros.svh
// assertion helpers shared by the encoder modules
// all of them sample on i_clk and are off while i_rst_n is low
`ifndef ESCAPED_RLE_BYTE_ENCODER_UNIT_MACROS_SVH
`define ESCAPED_RLE_BYTE_ENCODER_UNIT_MACROS_SVH

// condition must never hold
`define ERLE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// antecedent in one cycle requires consequent in the next
`define ERLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/erle_pkg.sv
`timescale 1ns / 1ps

package erle_pkg;

    // largest byte value, also the marker of a full chunk
    localparam logic [7:0] BYTE_MAX = 8'd255;

    // one input beat yields at most this many coded bytes
    localparam int CMD_BYTES = 4;
    localparam int CMD_NW    = $clog2(CMD_BYTES + 1);
    localparam int CMD_IW    = $clog2(CMD_BYTES);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // coded bytes of one input beat, in emit order
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CMD_NW-1:0]         nbytes;
        logic                      last;
    } t_cmd;

endpackage

>>> rtl/erle_stream_if.sv
`timescale 1ns / 1ps

// raw message channel
interface erle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// coded byte channel
interface erle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/erle_fifo.sv
`timescale 1ns / 1ps
`include "escaped_rle_byte_encoder_unit_macros.svh"

module erle_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  erle_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output erle_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int PW = $clog2(erle_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(erle_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(erle_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(erle_pkg::QUEUE_DEPTH - 1);

    erle_pkg::t_cmd r_mem [erle_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CNTW-1:0] n_cnt;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `ERLE_ASSERT_NEVER(a_push_full, i_push && o_full, "push into full queue")
    `ERLE_ASSERT_NEVER(a_pop_empty, i_pop && o_empty, "pop from empty queue")

endmodule

>>> rtl/erle_front.sv
`timescale 1ns / 1ps
`include "escaped_rle_byte_encoder_unit_macros.svh"

module erle_front #(
    parameter int MAX_RUN = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    erle_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output erle_pkg::t_cmd o_cmd
);

    localparam int CW = $clog2(MAX_RUN + 2);
    localparam logic [7:0]    LIT_MAX  = 8'(255 - MAX_RUN);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RUN);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_RUN + 1);

    // up to two bytes from closing a run or a chunk
    typedef struct packed {
        logic [1:0][7:0] b;
        logic [1:0]      n;
    } t_pair;

    logic          r_open;
    logic [7:0]    r_value;
    logic [CW-1:0] r_count;
    logic          n_open;
    logic [7:0]    n_value;
    logic [CW-1:0] n_count;

    logic          accept;
    logic          eq;
    logic [CW-1:0] pend;
    logic [CW-1:0] len1;
    logic [7:0]    val_mid;
    logic [CW-1:0] cnt_mid;
    t_pair         p;
    t_pair         q;
    logic [2:0]    k;

    // code a pending run: literal when lone and unambiguous, else marker and value
    function automatic t_pair flush_run(logic [CW-1:0] cnt, logic [7:0] val);
        t_pair         f;
        logic [CW-1:0] len;
        len = (cnt > MAX_CNT) ? ONE_CNT : cnt;
        if (cnt == ONE_CNT && val <= LIT_MAX) begin
            f.b[0] = val;
            f.b[1] = val;
            f.n    = 2'd1;
        end else begin
            f.b[0] = LIT_MAX + 8'(len);
            f.b[1] = val;
            f.n    = 2'd2;
        end
        return f;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // classify the beat against the open run
    always_comb begin
        eq      = r_open && (i_in.in_byte == r_value);
        pend    = (r_count > MAX_CNT) ? ONE_CNT : r_count;
        len1    = pend + ONE_CNT;
        p       = '0;
        q       = '0;
        val_mid = r_value;
        cnt_mid = len1;
        if (eq) begin
            if (len1 > MAX_CNT) begin
                p.b[0]  = erle_pkg::BYTE_MAX;
                p.b[1]  = r_value;
                p.n     = 2'd2;
                cnt_mid = FULL_CNT;
            end
        end else begin
            if (r_open) begin
                p = flush_run(r_count, r_value);
            end
            val_mid = i_in.in_byte;
            cnt_mid = ONE_CNT;
        end
        if (i_in.in_last) begin
            q = flush_run(cnt_mid, val_mid);
        end
    end

    // pack both parts into one command
    always_comb begin
        k = '0;
        for (int j = 0; j < erle_pkg::CMD_BYTES; j++) begin
            k = 3'(j) - {1'b0, p.n};
            if (3'(j) < {1'b0, p.n}) begin
                o_cmd.bytes[j] = p.b[j % 2];
            end else if (k < 3'd2) begin
                o_cmd.bytes[j] = q.b[k[0]];
            end else begin
                o_cmd.bytes[j] = '0;
            end
        end
        o_cmd.nbytes = erle_pkg::CMD_NW'({1'b0, p.n} + {1'b0, q.n});
        o_cmd.last   = i_in.in_last;
    end

    assign o_push = accept && (o_cmd.nbytes != '0);

    // run state after this beat
    always_comb begin
        n_open  = r_open;
        n_value = r_value;
        n_count = r_count;
        if (accept) begin
            if (i_in.in_last) begin
                n_open  = 1'b0;
                n_value = '0;
                n_count = '0;
            end else begin
                n_open  = 1'b1;
                n_value = val_mid;
                n_count = cnt_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_value <= '0;
            r_count <= '0;
        end else begin
            r_open  <= n_open;
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    `ERLE_ASSERT_NEXT(a_last_closes, accept && i_in.in_last, !r_open, "run left open after last")
    `ERLE_ASSERT_NEVER(a_open_count, r_open && (r_count == '0 || r_count > FULL_CNT), "bad run count")

endmodule

>>> rtl/erle_back.sv
`timescale 1ns / 1ps
`include "escaped_rle_byte_encoder_unit_macros.svh"

module erle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  erle_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    erle_out_if.source     o_out
);

    logic [erle_pkg::CMD_IW-1:0] r_idx;
    logic [erle_pkg::CMD_IW-1:0] n_idx;
    logic                        r_valid;
    logic                        n_valid;
    logic [7:0]                  r_byte;
    logic                        r_last;
    logic                        load;
    logic                        end_of_cmd;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    // move the next byte into the output register when it is free
    assign load       = !i_empty && (!r_valid || o_out.ready);
    assign end_of_cmd = ({1'b0, r_idx} == i_cmd.nbytes - erle_pkg::CMD_NW'(1));
    assign o_pop      = load && end_of_cmd;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = end_of_cmd ? '0 : r_idx + erle_pkg::CMD_IW'(1);
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_cmd.bytes[r_idx];
            r_last <= i_cmd.last && end_of_cmd;
        end
    end

    `ERLE_ASSERT_NEVER(a_idx_orphan, r_idx != '0 && i_empty, "byte index without command")

endmodule

>>> rtl/escaped_rle_byte_encoder_unit.sv
`timescale 1ns / 1ps
// channel   dir   payload              handshake
// i_in      in    in_byte[7:0] in_last valid / ready
// o_out     out   out_byte[7:0] out_last valid / ready
//
// an input beat is taken in one cycle whenever the command queue has room
// coded bytes leave at one per cycle from the output register when not stalled
// the sustained beat rate is set by the bytes each beat yields on the
// one-byte output port (an escaped literal yields two)
// synchronous active-low reset clears run state, queue and output valid
// an output stall fills the four-entry queue before i_in.ready drops

module escaped_rle_byte_encoder_unit #(
    parameter int MAX_RUN = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    erle_in_if.sink    i_in,
    erle_out_if.source o_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    erle_pkg::t_cmd cmd_in;
    erle_pkg::t_cmd cmd_out;

    // classify beats into byte commands
    erle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    // decoupling queue
    erle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    // serialize commands onto the output
    erle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
